>>> rtl/core/avfp_pkg.sv
// ----------------------------------------------------------------------------
// avfp_pkg
// Shared types and character codes for the ASCII vision frame parser.
// ----------------------------------------------------------------------------
package avfp_pkg;

    // Frame kinds as reported on the result channel
    localparam logic [1:0] KIND_DET = 2'd0;
    localparam logic [1:0] KIND_LOC = 2'd1;
    localparam logic [1:0] KIND_ACK = 2'd2;

    // Characters of the framing grammar
    localparam logic [7:0] CH_V     = 8'h56;  // 'V'
    localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
    localparam logic [7:0] CH_D     = 8'h44;  // 'D'
    localparam logic [7:0] CH_L     = 8'h4C;  // 'L'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    // Parse position inside a frame
    typedef enum logic [3:0] {
        ST_IDLE        = 4'd0,
        ST_TYPE        = 4'd1,
        ST_SEL         = 4'd2,
        ST_ACK_RES     = 4'd3,
        ST_ACK_END     = 4'd4,
        ST_FOUND       = 4'd5,
        ST_FOUND_COMMA = 4'd6,
        ST_NUM_START   = 4'd7,
        ST_NUM_FIRST   = 4'd8,
        ST_NUM_INT     = 4'd9,
        ST_NUM_FRAC    = 4'd10,
        ST_NUM_END     = 4'd11,
        ST_TS          = 4'd12,
        ST_LOC_END     = 4'd13
    } step_t;

endpackage

>>> rtl/core/ascii_vision_frame_parser.sv
// ----------------------------------------------------------------------------
// ascii_vision_frame_parser
// Frames 'V'...'#' ASCII messages from a byte stream and parses detection,
// location and acknowledge frames into one result per good frame.
//
// Input channel (in_valid/in_ready/rx_byte): one character per transfer.
// Result channel (out_valid/out_ready/fields): one transfer per well-formed
// frame, presented in the cycle after the '#' transfer. Malformed, truncated
// and overlength frames give nothing.
// One byte per cycle unless stalled. All parsing is incremental: each byte
// updates the frame state in a single pass (the decimal accumulate is a
// shift-add of the running value), so there is no per-frame processing time.
// Stall: the result sits in the output register; in_ready stays high while
// the register is empty or being drained in the same cycle, so a stalled
// receiver only blocks input once a result is waiting and not taken.
// Reset: parser hunts for 'V', output register empty, held fields zero.
// ----------------------------------------------------------------------------
module ascii_vision_frame_parser
    import avfp_pkg::*;
#(
    parameter int FRAME_BYTES = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         kind,
    output logic               found,
    output logic signed [31:0] x_tenths,
    output logic signed [31:0] y_tenths,
    output logic signed [31:0] distance_tenths,
    output logic [31:0]        stamp_ms,
    output logic [7:0]         ack_type,
    output logic               ack_result
);

    // Byte count holds up to FRAME_BYTES-1
    localparam int             CNT_W    = $clog2(FRAME_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BYTES - 1);

    // Frame state
    logic             in_frame_reg,  in_frame_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    step_t            step_reg,      step_next;
    logic [1:0]       fkind_reg,     fkind_next;
    logic             frame_bad_reg, frame_bad_next;
    logic             neg_reg,       neg_next;
    logic [31:0]      accum_reg,     accum_next;
    logic [1:0]       vidx_reg,      vidx_next;
    logic [31:0]      held_reg [3];
    logic [31:0]      held_next [3];
    logic             hfound_reg,    hfound_next;
    logic [7:0]       htype_reg,     htype_next;
    logic             hres_reg,      hres_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       kind_reg;
    logic             found_reg;
    logic [31:0]      x_reg, y_reg, dist_reg, stamp_reg;
    logic [7:0]       ack_type_reg;
    logic             ack_res_reg;

    logic        in_fire;
    logic        is_digit;
    logic        step_bad;
    logic        step_done;
    logic        result_hit;
    logic [31:0] accum_dig;
    logic [31:0] value_signed;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

    // accum * 10 + digit, wraps at 32 bits
    assign accum_dig    = (accum_reg << 3) + (accum_reg << 1) + {28'd0, rx_byte[3:0]};
    assign value_signed = neg_reg ? (32'd0 - accum_dig) : accum_dig;

    // Next-state logic for the parse
    always_comb
    begin
        in_frame_next  = in_frame_reg;
        count_next     = count_reg;
        step_next      = step_reg;
        fkind_next     = fkind_reg;
        frame_bad_next = frame_bad_reg;
        neg_next       = neg_reg;
        accum_next     = accum_reg;
        vidx_next      = vidx_reg;
        held_next      = held_reg;
        hfound_next    = hfound_reg;
        htype_next     = htype_reg;
        hres_next      = hres_reg;
        step_bad       = 1'b0;
        step_done      = 1'b0;
        result_hit     = 1'b0;

        if (in_fire)
        begin
            if (rx_byte == CH_V)
            begin
                // start or restart a frame
                in_frame_next  = 1'b1;
                count_next     = CNT_W'(1);
                step_next      = ST_TYPE;
                fkind_next     = KIND_DET;
                frame_bad_next = 1'b0;
                neg_next       = 1'b0;
                accum_next     = 32'd0;
                vidx_next      = 2'd0;
            end
            else if (in_frame_reg)
            begin
                if (count_reg >= CNT_LAST)
                begin
                    // overlength: drop and hunt
                    in_frame_next = 1'b0;
                    count_next    = '0;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                    if (!frame_bad_reg)
                    begin
                        case (step_reg)
                            ST_TYPE:
                            begin
                                htype_next = rx_byte;
                                step_next  = ST_SEL;
                            end
                            ST_SEL:
                            begin
                                if (htype_reg == CH_D && rx_byte == CH_COMMA)
                                begin
                                    fkind_next = KIND_DET;
                                    step_next  = ST_FOUND;
                                end
                                else if (htype_reg == CH_L && rx_byte == CH_COMMA)
                                begin
                                    fkind_next = KIND_LOC;
                                    vidx_next  = 2'd0;
                                    accum_next = 32'd0;
                                    neg_next   = 1'b0;
                                    step_next  = ST_NUM_START;
                                end
                                else if (rx_byte == CH_A)
                                begin
                                    fkind_next = KIND_ACK;
                                    step_next  = ST_ACK_RES;
                                end
                                else
                                begin
                                    step_bad = 1'b1;
                                end
                            end
                            ST_ACK_RES:
                            begin
                                if (rx_byte == CH_ZERO || rx_byte == CH_ONE)
                                begin
                                    hres_next = rx_byte[0];
                                    step_next = ST_ACK_END;
                                end
                                else
                                begin
                                    step_bad = 1'b1;
                                end
                            end
                            ST_ACK_END:
                            begin
                                if (rx_byte == CH_HASH)
                                    step_done = 1'b1;
                                else
                                    step_bad = 1'b1;
                            end
                            ST_FOUND:
                            begin
                                if (rx_byte == CH_ZERO || rx_byte == CH_ONE)
                                begin
                                    hfound_next = rx_byte[0];
                                    step_next   = ST_FOUND_COMMA;
                                end
                                else
                                begin
                                    step_bad = 1'b1;
                                end
                            end
                            ST_FOUND_COMMA:
                            begin
                                if (rx_byte == CH_COMMA)
                                begin
                                    vidx_next  = 2'd0;
                                    accum_next = 32'd0;
                                    neg_next   = 1'b0;
                                    step_next  = ST_NUM_START;
                                end
                                else
                                begin
                                    step_bad = 1'b1;
                                end
                            end
                            ST_NUM_START:
                            begin
                                if (rx_byte == CH_MINUS)
                                begin
                                    neg_next  = 1'b1;
                                    step_next = ST_NUM_FIRST;
                                end
                                else if (is_digit)
                                begin
                                    accum_next = accum_dig;
                                    step_next  = ST_NUM_INT;
                                end
                                else
                                begin
                                    step_bad = 1'b1;
                                end
                            end
                            ST_NUM_FIRST:
                            begin
                                if (is_digit)
                                begin
                                    accum_next = accum_dig;
                                    step_next  = ST_NUM_INT;
                                end
                                else
                                begin
                                    step_bad = 1'b1;
                                end
                            end
                            ST_NUM_INT:
                            begin
                                if (is_digit)
                                    accum_next = accum_dig;
                                else if (rx_byte == CH_DOT)
                                    step_next = ST_NUM_FRAC;
                                else
                                    step_bad = 1'b1;
                            end
                            ST_NUM_FRAC:
                            begin
                                if (is_digit)
                                begin
                                    accum_next = accum_dig;
                                    for (int i = 0; i < 3; i++)
                                    begin
                                        if (vidx_reg == 2'(i))
                                            held_next[i] = value_signed;
                                    end
                                    step_next = ST_NUM_END;
                                end
                                else
                                begin
                                    step_bad = 1'b1;
                                end
                            end
                            ST_NUM_END:
                            begin
                                if (fkind_reg == KIND_LOC)
                                begin
                                    if (rx_byte == CH_COMMA)
                                    begin
                                        accum_next = 32'd0;
                                        step_next  = ST_TS;
                                    end
                                    else
                                    begin
                                        step_bad = 1'b1;
                                    end
                                end
                                else if (vidx_reg < 2'd2 && rx_byte == CH_COMMA)
                                begin
                                    vidx_next  = vidx_reg + 2'd1;
                                    accum_next = 32'd0;
                                    neg_next   = 1'b0;
                                    step_next  = ST_NUM_START;
                                end
                                else if (vidx_reg == 2'd2 && rx_byte == CH_HASH)
                                begin
                                    step_done = 1'b1;
                                end
                                else
                                begin
                                    step_bad = 1'b1;
                                end
                            end
                            ST_TS:
                            begin
                                if (is_digit)
                                    accum_next = accum_dig;
                                else if (rx_byte == CH_COMMA)
                                    step_next = ST_LOC_END;
                                else
                                    step_bad = 1'b1;
                            end
                            ST_LOC_END:
                            begin
                                if (rx_byte == CH_HASH)
                                    step_done = 1'b1;
                                else
                                    step_bad = 1'b1;
                            end
                            default:
                            begin
                                step_bad = 1'b1;
                            end
                        endcase
                    end
                    frame_bad_next = frame_bad_reg | step_bad;

                    if (rx_byte == CH_HASH)
                    begin
                        in_frame_next = 1'b0;
                        count_next    = '0;
                        result_hit    = step_done && !frame_bad_reg;
                    end
                end
            end
        end
    end

    // Result register: held until taken
    always_comb
    begin
        if (result_hit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            count_reg     <= '0;
            step_reg      <= ST_IDLE;
            fkind_reg     <= KIND_DET;
            frame_bad_reg <= 1'b0;
            neg_reg       <= 1'b0;
            accum_reg     <= 32'd0;
            vidx_reg      <= 2'd0;
            held_reg      <= '{default: 32'd0};
            hfound_reg    <= 1'b0;
            htype_reg     <= 8'd0;
            hres_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            fkind_reg     <= fkind_next;
            frame_bad_reg <= frame_bad_next;
            neg_reg       <= neg_next;
            accum_reg     <= accum_next;
            vidx_reg      <= vidx_next;
            held_reg      <= held_next;
            hfound_reg    <= hfound_next;
            htype_reg     <= htype_next;
            hres_reg      <= hres_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload: on the '#' the held fields are already final
    always_ff @(posedge clk)
    begin
        if (result_hit)
        begin
            kind_reg     <= fkind_reg;
            found_reg    <= (fkind_reg == KIND_DET) ? hfound_reg : 1'b0;
            x_reg        <= (fkind_reg != KIND_ACK) ? held_reg[0] : 32'd0;
            y_reg        <= (fkind_reg == KIND_DET) ? held_reg[1] : 32'd0;
            dist_reg     <= (fkind_reg == KIND_DET) ? held_reg[2] : 32'd0;
            stamp_reg    <= (fkind_reg == KIND_LOC) ? accum_reg : 32'd0;
            ack_type_reg <= (fkind_reg == KIND_ACK) ? htype_reg : 8'd0;
            ack_res_reg  <= (fkind_reg == KIND_ACK) ? hres_reg : 1'b0;
        end
    end

    assign out_valid       = out_valid_reg;
    assign kind            = kind_reg;
    assign found           = found_reg;
    assign x_tenths        = x_reg;
    assign y_tenths        = y_reg;
    assign distance_tenths = dist_reg;
    assign stamp_ms        = stamp_reg;
    assign ack_type        = ack_type_reg;
    assign ack_result      = ack_res_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg <= CNT_LAST) && (in_frame_reg || count_reg == '0))
        else $error("byte count out of range or nonzero while hunting");

    a_v_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && rx_byte == CH_V) |=>
            (in_frame_reg && count_reg == CNT_W'(1) && step_reg == ST_TYPE && !frame_bad_reg))
        else $error("'V' did not restart the frame");

    a_result_on_hash: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && rx_byte != CH_HASH) |=> !out_valid_reg)
        else $error("result produced by a byte other than '#'");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (kind_reg == KIND_DET || kind_reg == KIND_LOC || kind_reg == KIND_ACK))
        else $error("result carries an unused kind code");

    a_ack_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_ACK) |-> (x_reg == 32'd0 && stamp_reg == 32'd0))
        else $error("acknowledge result carries number fields");

endmodule
